### sv/chd_pkg.sv
// Shared types and constants for the chunked body deframer.
// Used by chd_cfg, chd_core and the top level http_body_chunked_deframer.
`default_nettype none

package chd_pkg;

    localparam int LENGTH_BITS_DEF = 40;

    // size_limit after reset, cut to the length width where it is loaded
    localparam longint unsigned SIZE_LIMIT_RESET = 64'd1048576;

    // configuration register indexes
    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_BODY_MODE       = 2'd0;
    localparam t_cfg_idx CFG_DECLARED_LENGTH = 2'd1;
    localparam t_cfg_idx CFG_SIZE_LIMIT      = 2'd2;

    // body modes
    typedef logic [1:0] t_mode;
    localparam t_mode MODE_NONE   = 2'd0;
    localparam t_mode MODE_LENGTH = 2'd1;
    localparam t_mode MODE_CHUNKED = 2'd2;
    localparam t_mode MODE_CLOSE  = 2'd3;

    // error codes
    typedef logic [1:0] t_err;
    localparam t_err ERR_NONE   = 2'd0;
    localparam t_err ERR_SIZE   = 2'd1;
    localparam t_err ERR_SUFFIX = 2'd2;
    localparam t_err ERR_LARGE  = 2'd3;

    typedef struct packed {
        logic [7:0] body_byte;
        logic       body_valid;
        logic       finished;
        t_err       error_code;
    } t_result;

endpackage

`default_nettype wire

### sv/http_body_chunked_deframer.sv
// HTTP/1 message body deframer: input register, parser step, result register.
// Depends on chd_pkg, chd_cfg and chd_core.
//
// Usage:
//   Input channel (i_valid/o_ready) carries one raw body byte per item, or an
//   end-of-stream marker. Output channel (o_valid/i_ready) carries exactly one
//   result per item: a payload byte with o_body_valid, o_finished when the
//   body completes, and the sticky o_error_code.
//   The configuration port (i_cfg_wr_en, i_cfg_index, i_cfg_data) writes body
//   mode, declared length and size limit; write only while no item is in
//   flight. Body mode and declared length are sampled when a body starts.
//   An accepted item passes through the input register, then through the
//   parser step into the result register.
//   Throughput: one item per cycle while the receiver keeps up; the parser
//   state updates with each step, so each item sees the state its predecessor left.
//   Reset (synchronous, active low) clears the parser to idle, clears the
//   error and loads the register reset values.
//   When the receiver stalls, the result register holds, the input register
//   then fills and o_ready drops; no item is lost or repeated.
`default_nettype none

module http_body_chunked_deframer #(
    parameter int LENGTH_BITS = chd_pkg::LENGTH_BITS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // configuration
    input  wire logic                   i_cfg_wr_en,
    input  wire chd_pkg::t_cfg_idx      i_cfg_index,
    input  wire logic [LENGTH_BITS-1:0] i_cfg_data,
    // input items
    input  wire logic                   i_valid,
    output logic                        o_ready,
    input  wire logic [7:0]             i_data_byte,
    input  wire logic                   i_end_of_stream,
    // result items
    output logic                        o_valid,
    input  wire logic                   i_ready,
    output logic [7:0]                  o_body_byte,
    output logic                        o_body_valid,
    output logic                        o_finished,
    output chd_pkg::t_err               o_error_code
);
    import chd_pkg::*;

    t_mode                  w_body_mode;
    logic [LENGTH_BITS-1:0] w_declared_length;
    logic [LENGTH_BITS-1:0] w_size_limit;
    t_result                w_result;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_eos;
    logic       r_out_valid;
    t_result    r_out;
    logic       w_advance;

    chd_cfg #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_cfg (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_body_mode       (w_body_mode),
        .o_declared_length (w_declared_length),
        .o_size_limit      (w_size_limit)
    );

    // item moves from the input register into the result register
    assign w_advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready   = !r_in_valid || w_advance;

    chd_core #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_core (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_step            (w_advance),
        .i_data_byte       (r_in_byte),
        .i_end_of_stream   (r_in_eos),
        .i_body_mode       (w_body_mode),
        .i_declared_length (w_declared_length),
        .i_size_limit      (w_size_limit),
        .o_result          (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_byte <= i_data_byte;
            r_in_eos  <= i_end_of_stream;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out <= w_result;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_body_byte  = r_out.body_byte;
    assign o_body_valid = r_out.body_valid;
    assign o_finished   = r_out.finished;
    assign o_error_code = r_out.error_code;

endmodule

`default_nettype wire

### sv/chd_cfg.sv
// Configuration register file of the deframer: body mode, declared length, size limit.
// Depends on chd_pkg.
`default_nettype none

module chd_cfg #(
    parameter int LENGTH_BITS = chd_pkg::LENGTH_BITS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_wr_en,
    input  wire chd_pkg::t_cfg_idx      i_cfg_index,
    input  wire logic [LENGTH_BITS-1:0] i_cfg_data,
    output chd_pkg::t_mode              o_body_mode,
    output logic [LENGTH_BITS-1:0]      o_declared_length,
    output logic [LENGTH_BITS-1:0]      o_size_limit
);
    import chd_pkg::*;

    t_mode                  r_body_mode;
    logic [LENGTH_BITS-1:0] r_declared_length;
    logic [LENGTH_BITS-1:0] r_size_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_body_mode       <= MODE_NONE;
            r_declared_length <= '0;
            r_size_limit      <= LENGTH_BITS'(SIZE_LIMIT_RESET);
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_BODY_MODE:       r_body_mode       <= i_cfg_data[1:0];
                CFG_DECLARED_LENGTH: r_declared_length <= i_cfg_data;
                CFG_SIZE_LIMIT:      r_size_limit      <= i_cfg_data;
                default: ;  // no register at this index
            endcase
        end
    end

    assign o_body_mode       = r_body_mode;
    assign o_declared_length = r_declared_length;
    assign o_size_limit      = r_size_limit;

endmodule

`default_nettype wire

### sv/chd_core.sv
// Parser state and per-item step logic of the deframer (phase, counters, sticky error).
// Depends on chd_pkg.
`default_nettype none

module chd_core #(
    parameter int LENGTH_BITS = chd_pkg::LENGTH_BITS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_step,
    input  wire logic [7:0]             i_data_byte,
    input  wire logic                   i_end_of_stream,
    input  wire chd_pkg::t_mode         i_body_mode,
    input  wire logic [LENGTH_BITS-1:0] i_declared_length,
    input  wire logic [LENGTH_BITS-1:0] i_size_limit,
    output chd_pkg::t_result            o_result
);
    import chd_pkg::*;

    localparam logic [2:0] PH_IDLE       = 3'd0;
    localparam logic [2:0] PH_LEN        = 3'd1;
    localparam logic [2:0] PH_SIZE_FIRST = 3'd2;
    localparam logic [2:0] PH_SIZE       = 3'd3;
    localparam logic [2:0] PH_DATA       = 3'd4;
    localparam logic [2:0] PH_SUFFIX     = 3'd5;
    localparam logic [2:0] PH_CLOSE      = 3'd6;

    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;

    localparam int SUM_BITS = LENGTH_BITS + 2;

    // {is_hex, value}
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] res;
        res = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) res = {1'b1, 4'(c - 8'h30)};
        else if (c >= 8'h61 && c <= 8'h66) res = {1'b1, 4'(c - 8'h57)};
        else if (c >= 8'h41 && c <= 8'h46) res = {1'b1, 4'(c - 8'h37)};
        return res;
    endfunction

    logic [2:0]             r_phase, n_phase;
    logic [LENGTH_BITS-1:0] r_rem,   n_rem;
    logic [LENGTH_BITS-1:0] r_acc,   n_acc;
    logic [LENGTH_BITS:0]   r_tot,   n_tot;
    logic                   r_cr,    n_cr;
    t_err                   r_err,   n_err;

    logic                   v_valid;
    logic                   v_fin;
    logic [4:0]             v_hex;
    logic [LENGTH_BITS-1:0] v_rem_dec;
    logic [SUM_BITS-1:0]    v_limit;

    assign v_hex   = hex_decode(i_data_byte);
    assign v_limit = SUM_BITS'(i_size_limit);

    always_comb begin
        n_phase   = r_phase;
        n_rem     = r_rem;
        n_acc     = r_acc;
        n_tot     = r_tot;
        n_cr      = r_cr;
        n_err     = r_err;
        v_valid   = 1'b0;
        v_fin     = 1'b0;
        v_rem_dec = '0;

        if (r_err == ERR_NONE) begin
            // first item of a body: set up for the current mode
            if (r_phase == PH_IDLE || r_phase > PH_CLOSE) begin
                n_phase = PH_IDLE;
                n_rem   = '0;
                n_acc   = '0;
                n_tot   = '0;
                n_cr    = 1'b0;
                unique case (i_body_mode)
                    MODE_NONE: v_fin = 1'b1;
                    MODE_LENGTH: begin
                        if (i_declared_length > i_size_limit) begin
                            n_err = ERR_LARGE;
                        end else if (i_declared_length == '0) begin
                            v_fin = 1'b1;
                        end else begin
                            n_rem   = i_declared_length;
                            n_phase = PH_LEN;
                        end
                    end
                    MODE_CHUNKED: n_phase = PH_SIZE_FIRST;
                    MODE_CLOSE:   n_phase = PH_CLOSE;
                    default: ;
                endcase
            end

            if (n_err == ERR_NONE && !v_fin && n_phase != PH_IDLE) begin
                v_rem_dec = n_rem - LENGTH_BITS'(1);
                if (n_phase == PH_CLOSE) begin
                    if (i_end_of_stream) begin
                        v_fin = 1'b1;
                    end else if (SUM_BITS'(n_tot) + SUM_BITS'(1) > v_limit) begin
                        n_err = ERR_LARGE;
                    end else begin
                        n_tot   = n_tot + (LENGTH_BITS+1)'(1);
                        v_valid = 1'b1;
                    end
                end else if (!i_end_of_stream) begin
                    unique case (n_phase)
                        PH_LEN: begin
                            v_valid = 1'b1;
                            n_tot   = n_tot + (LENGTH_BITS+1)'(1);
                            n_rem   = v_rem_dec;
                            if (v_rem_dec == '0) v_fin = 1'b1;
                        end
                        PH_SIZE_FIRST, PH_SIZE: begin
                            if (n_cr) begin
                                n_cr = 1'b0;
                                if (i_data_byte != CHAR_LF || n_phase == PH_SIZE_FIRST) begin
                                    n_err = ERR_SIZE;
                                end else if (SUM_BITS'(n_tot) + SUM_BITS'(n_acc) > v_limit) begin
                                    n_err = ERR_LARGE;
                                end else begin
                                    n_rem   = n_acc;
                                    n_phase = (n_acc == '0) ? PH_SUFFIX : PH_DATA;
                                end
                            end else if (i_data_byte == CHAR_CR) begin
                                n_cr = 1'b1;
                            end else if (!v_hex[4] || n_acc[LENGTH_BITS-1 -: 4] != 4'd0) begin
                                n_err = ERR_SIZE;
                            end else begin
                                n_acc   = {n_acc[LENGTH_BITS-5:0], v_hex[3:0]};
                                n_phase = PH_SIZE;
                            end
                        end
                        PH_DATA: begin
                            v_valid = 1'b1;
                            n_tot   = n_tot + (LENGTH_BITS+1)'(1);
                            n_rem   = v_rem_dec;
                            if (v_rem_dec == '0) n_phase = PH_SUFFIX;
                        end
                        PH_SUFFIX: begin
                            if (n_cr) begin
                                n_cr = 1'b0;
                                if (i_data_byte != CHAR_LF) begin
                                    n_err = ERR_SUFFIX;
                                end else if (n_acc == '0) begin
                                    v_fin = 1'b1;
                                end else begin
                                    n_acc   = '0;
                                    n_phase = PH_SIZE_FIRST;
                                end
                            end else if (i_data_byte == CHAR_CR) begin
                                n_cr = 1'b1;
                            end else begin
                                n_err = ERR_SUFFIX;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            // body complete: back to idle for the next one
            if (v_fin) begin
                n_phase = PH_IDLE;
                n_rem   = '0;
                n_acc   = '0;
                n_tot   = '0;
                n_cr    = 1'b0;
            end
        end

        if (n_err != ERR_NONE) begin
            v_valid = 1'b0;
            v_fin   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_rem   <= '0;
            r_acc   <= '0;
            r_tot   <= '0;
            r_cr    <= 1'b0;
            r_err   <= ERR_NONE;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_rem   <= n_rem;
            r_acc   <= n_acc;
            r_tot   <= n_tot;
            r_cr    <= n_cr;
            r_err   <= n_err;
        end
    end

    assign o_result.body_byte  = v_valid ? i_data_byte : 8'd0;
    assign o_result.body_valid = v_valid;
    assign o_result.finished   = v_fin;
    assign o_result.error_code = n_err;

endmodule

`default_nettype wire

### tb/http_body_chunked_deframer_test.sv
// Self-checking testbench for http_body_chunked_deframer: raw body bytes in, payload bytes out.
// A byte-level predictor of the deframer is checked against every result item.
// Depends on chd_pkg and the http_body_chunked_deframer RTL.
`default_nettype none

module http_body_chunked_deframer_test;

    import chd_pkg::*;

    localparam int LEN_W = LENGTH_BITS_DEF;

    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_ZERO = 8'h30;

    typedef enum logic [2:0] {
        BODY_IDLE, BODY_LENGTH, BODY_SIZE_FIRST, BODY_SIZE, BODY_DATA, BODY_SUFFIX, BODY_CLOSE
    } t_body_phase;

    typedef struct packed {
        logic [7:0] data;
        logic       eos;
    } t_raw_item;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_cfg_wr_en = 1'b0;
    t_cfg_idx         i_cfg_index = CFG_BODY_MODE;
    logic [LEN_W-1:0] i_cfg_data = '0;
    logic             i_valid = 1'b0;
    logic             o_ready;
    logic [7:0]       i_data_byte = 8'h00;
    logic             i_end_of_stream = 1'b0;
    logic             o_valid;
    logic             i_ready = 1'b0;
    logic [7:0]       o_body_byte;
    logic             o_body_valid;
    logic             o_finished;
    t_err             o_error_code;

    http_body_chunked_deframer #(.LENGTH_BITS(LEN_W)) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_data_byte     (i_data_byte),
        .i_end_of_stream (i_end_of_stream),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_body_byte     (o_body_byte),
        .o_body_valid    (o_body_valid),
        .o_finished      (o_finished),
        .o_error_code    (o_error_code)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ---------------- predictor state and its copy of the registers ----------------
    t_mode            cfg_mode = MODE_NONE;
    logic [LEN_W-1:0] cfg_decl_len = '0;
    logic [LEN_W-1:0] cfg_limit = LEN_W'(SIZE_LIMIT_RESET);

    t_body_phase      body_phase = BODY_IDLE;
    logic [LEN_W-1:0] bytes_left = '0;
    logic [LEN_W-1:0] size_acc = '0;
    logic [LEN_W:0]   bytes_read = '0;
    logic             cr_seen = 1'b0;
    t_err             sticky_err = ERR_NONE;

    t_raw_item raw_stream[$];
    t_result   predicted_results[$];
    int        stim_items = 0;
    int        accepted_count = 0;
    int        offered_seen = 0;
    int        result_count = 0;
    int        fail_count = 0;
    int        send_idle_pct = 19;
    int        recv_idle_pct = 67;
    logic      recv_hold = 1'b0;

    function automatic int hex_digit(logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
        if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
        if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
        return -1;
    endfunction

    function automatic void clear_body();
        body_phase = BODY_IDLE;
        bytes_left = '0;
        size_acc = '0;
        bytes_read = '0;
        cr_seen = 1'b0;
    endfunction

    function automatic void decode_body_byte(input logic [7:0] b, input logic eos,
                                             output t_result r);
        logic        pass_byte;
        logic        done;
        int          digit;
        logic [41:0] bytes_after;
        pass_byte = 1'b0;
        done = 1'b0;
        if (sticky_err == ERR_NONE) begin
            // a new body picks up the mode and declared length here
            if (body_phase == BODY_IDLE) begin
                clear_body();
                case (cfg_mode)
                    MODE_NONE: done = 1'b1;
                    MODE_LENGTH: begin
                        if (cfg_decl_len > cfg_limit) begin
                            sticky_err = ERR_LARGE;
                        end else if (cfg_decl_len == '0) begin
                            done = 1'b1;
                        end else begin
                            bytes_left = cfg_decl_len;
                            body_phase = BODY_LENGTH;
                        end
                    end
                    MODE_CHUNKED: body_phase = BODY_SIZE_FIRST;
                    default: body_phase = BODY_CLOSE;
                endcase
            end
            if (sticky_err == ERR_NONE && !done && body_phase != BODY_IDLE) begin
                if (body_phase == BODY_CLOSE) begin
                    if (eos) begin
                        done = 1'b1;
                        clear_body();
                    end else if ({1'b0, bytes_read} + 42'd1 > {2'b00, cfg_limit}) begin
                        sticky_err = ERR_LARGE;
                    end else begin
                        bytes_read = bytes_read + 1'b1;
                        pass_byte = 1'b1;
                    end
                end else if (!eos) begin
                    case (body_phase)
                        BODY_LENGTH, BODY_DATA: begin
                            pass_byte = 1'b1;
                            bytes_read = bytes_read + 1'b1;
                            bytes_left = bytes_left - 1'b1;
                            if (bytes_left == '0) begin
                                if (body_phase == BODY_LENGTH) begin
                                    done = 1'b1;
                                    clear_body();
                                end else begin
                                    body_phase = BODY_SUFFIX;
                                end
                            end
                        end
                        BODY_SIZE_FIRST, BODY_SIZE: begin
                            bytes_after = {1'b0, bytes_read} + {2'b00, size_acc};
                            if (cr_seen) begin
                                cr_seen = 1'b0;
                                if (b != CH_LF || body_phase == BODY_SIZE_FIRST) begin
                                    sticky_err = ERR_SIZE;
                                end else if (bytes_after > {2'b00, cfg_limit}) begin
                                    sticky_err = ERR_LARGE;
                                end else begin
                                    bytes_left = size_acc;
                                    body_phase = (size_acc == '0) ? BODY_SUFFIX : BODY_DATA;
                                end
                            end else if (b == CH_CR) begin
                                cr_seen = 1'b1;
                            end else begin
                                digit = hex_digit(b);
                                // one more digit must not push bits out of the top
                                if (digit < 0 || size_acc[LEN_W-1 -: 4] != 4'h0) begin
                                    sticky_err = ERR_SIZE;
                                end else begin
                                    size_acc = {size_acc[LEN_W-5:0], digit[3:0]};
                                    body_phase = BODY_SIZE;
                                end
                            end
                        end
                        BODY_SUFFIX: begin
                            if (cr_seen) begin
                                cr_seen = 1'b0;
                                if (b != CH_LF) begin
                                    sticky_err = ERR_SUFFIX;
                                end else if (size_acc == '0) begin
                                    done = 1'b1;
                                    clear_body();
                                end else begin
                                    size_acc = '0;
                                    body_phase = BODY_SIZE_FIRST;
                                end
                            end else if (b == CH_CR) begin
                                cr_seen = 1'b1;
                            end else begin
                                sticky_err = ERR_SUFFIX;
                            end
                        end
                        default: ;
                    endcase
                end
            end
        end
        if (sticky_err != ERR_NONE) begin
            pass_byte = 1'b0;
            done = 1'b0;
        end
        r.body_byte = pass_byte ? b : 8'h00;
        r.body_valid = pass_byte;
        r.finished = done;
        r.error_code = sticky_err;
    endfunction

    function automatic void log_mismatch(string msg);
        fail_count++;
        if (fail_count <= 10) $display("%s", msg);
    endfunction

    // mirror register writes, predict accepted items, check result items
    always @(posedge i_clk) begin : track_and_check
        t_result got;
        t_result want;
        t_result predicted;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                got.body_byte = o_body_byte;
                got.body_valid = o_body_valid;
                got.finished = o_finished;
                got.error_code = o_error_code;
                if (predicted_results.size() == 0) begin
                    log_mismatch($sformatf("result %0d arrived with nothing expected",
                                           result_count));
                end else begin
                    want = predicted_results.pop_front();
                    if (got !== want)
                        log_mismatch($sformatf(
                            "result %0d: expected byte %02h valid %0b fin %0b err %0d, got byte %02h valid %0b fin %0b err %0d",
                            result_count, want.body_byte, want.body_valid, want.finished,
                            want.error_code, got.body_byte, got.body_valid, got.finished,
                            got.error_code));
                end
                result_count++;
            end
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_BODY_MODE:       cfg_mode = i_cfg_data[1:0];
                    CFG_DECLARED_LENGTH: cfg_decl_len = i_cfg_data;
                    CFG_SIZE_LIMIT:      cfg_limit = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_valid && o_ready) begin
                decode_body_byte(i_data_byte, i_end_of_stream, predicted);
                predicted_results.push_back(predicted);
                accepted_count++;
            end
        end
    end

    // sender: a new item goes out once the previous one was taken
    always @(negedge i_clk) begin : offer_items
        t_raw_item nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || accepted_count != offered_seen) begin
            offered_seen = accepted_count;
            if (raw_stream.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt = raw_stream.pop_front();
                i_valid <= 1'b1;
                i_data_byte <= nxt.data;
                i_end_of_stream <= nxt.eos;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin : accept_results
        i_ready <= i_rst_n && !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end

    // long receiver stall while the sender keeps going, to back up the pipeline
    initial begin : hold_receiver
        while (!(accepted_count >= 1000 && raw_stream.size() >= 16)) @(posedge i_clk);
        recv_hold = 1'b1;
        repeat (48) @(posedge i_clk);
        recv_hold = 1'b0;
    end

    initial begin : watchdog
        #5_000_000;
        $display("http_body_chunked_deframer: mismatch");
        $finish;
    end

    // ---------------- stimulus helpers ----------------
    task automatic push_raw(logic [7:0] b, logic eos);
        t_raw_item it;
        it.data = b;
        it.eos = eos;
        raw_stream.push_back(it);
        stim_items++;
    endtask

    // stray end-of-stream items are harmless in length and chunked bodies
    task automatic push_framed(logic [7:0] b);
        if ($urandom_range(99) < 4) push_raw(8'($urandom_range(255)), 1'b1);
        push_raw(b, 1'b0);
    endtask

    function automatic logic [7:0] hex_char(logic [3:0] n, logic upper);
        if (n < 4'd10) return CH_ZERO + n;
        return (upper ? 8'h41 : 8'h61) + n - 8'd10;
    endfunction

    task automatic queue_size_line(int unsigned size, int unsigned pad);
        logic [3:0]  nibbles[$];
        int unsigned rest;
        rest = size;
        do begin
            nibbles.push_front(rest[3:0]);
            rest = rest >> 4;
        end while (rest != 0);
        repeat (pad) push_framed(CH_ZERO);
        foreach (nibbles[k]) push_framed(hex_char(nibbles[k], 1'($urandom_range(1))));
        push_framed(CH_CR);
        push_framed(CH_LF);
    endtask

    task automatic queue_chunked_body(int unsigned chunks);
        int unsigned size;
        repeat (chunks) begin
            size = ($urandom_range(4) == 0) ? $urandom_range(17, 48) : $urandom_range(1, 16);
            queue_size_line(size, ($urandom_range(2) == 0) ? $urandom_range(1, 9) : 0);
            repeat (size) push_framed(8'($urandom_range(255)));
            push_framed(CH_CR);
            push_framed(CH_LF);
        end
        queue_size_line(0, ($urandom_range(3) == 0) ? $urandom_range(1, 9) : 0);
        push_framed(CH_CR);
        push_framed(CH_LF);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [LEN_W-1:0] val);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic wait_drained();
        while (raw_stream.size() != 0 || i_valid || predicted_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic [LEN_W-1:0] roomy_limit();
        case ($urandom_range(2))
            0: return LEN_W'($urandom_range(200, 5000));
            1: return LEN_W'(SIZE_LIMIT_RESET);
            default: return '1;
        endcase
    endfunction

    initial begin : run_stimulus
        t_mode            mode;
        int unsigned      decl;
        int unsigned      lim;
        int unsigned      pick;
        logic [7:0]       junk;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset registers give no-body mode
        push_raw(8'h00, 1'b0);
        push_raw(8'hFF, 1'b1);
        wait_drained();
        // zero limit: empty length body, zero chunk, close on the starting item
        write_reg(CFG_SIZE_LIMIT, '0);
        write_reg(CFG_BODY_MODE, MODE_LENGTH);
        push_raw(8'hA5, 1'b0);
        wait_drained();
        write_reg(CFG_BODY_MODE, MODE_CHUNKED);
        push_raw(CH_ZERO, 1'b0);
        push_raw(CH_CR, 1'b0);
        push_raw(CH_LF, 1'b0);
        push_raw(CH_CR, 1'b0);
        push_raw(CH_LF, 1'b0);
        wait_drained();
        write_reg(CFG_BODY_MODE, MODE_CLOSE);
        push_raw(8'h5A, 1'b1);
        wait_drained();
        // declared length exactly at the limit, early end-of-stream first
        write_reg(CFG_DECLARED_LENGTH, LEN_W'(3));
        write_reg(CFG_SIZE_LIMIT, LEN_W'(3));
        write_reg(CFG_BODY_MODE, MODE_LENGTH);
        push_raw(8'h3C, 1'b1);
        push_raw(8'h00, 1'b0);
        push_raw(8'hFF, 1'b0);
        push_raw(CH_CR, 1'b0);
        wait_drained();
        // widest limit and length, one-byte chunk with a leading zero
        write_reg(CFG_SIZE_LIMIT, '1);
        write_reg(CFG_DECLARED_LENGTH, '1);
        write_reg(CFG_BODY_MODE, MODE_CHUNKED);
        push_raw(CH_ZERO, 1'b0);
        push_raw(8'h31, 1'b0);
        push_raw(CH_CR, 1'b0);
        push_raw(CH_LF, 1'b0);
        push_raw(8'h80, 1'b0);
        push_raw(CH_CR, 1'b0);
        push_raw(CH_LF, 1'b0);
        push_raw(CH_ZERO, 1'b0);
        push_raw(CH_CR, 1'b0);
        push_raw(CH_LF, 1'b0);
        push_raw(CH_CR, 1'b0);
        push_raw(CH_LF, 1'b0);
        wait_drained();

        // random: whole bodies only, no errors, so sticky state stays clear
        while (stim_items < 1425) begin
            if (stim_items < 495) begin
                send_idle_pct = 19;
                recv_idle_pct = 67;
            end else if (stim_items < 960) begin
                send_idle_pct = 67;
                recv_idle_pct = 19;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            pick = $urandom_range(99);
            mode = (pick < 10) ? MODE_NONE : (pick < 35) ? MODE_LENGTH :
                   (pick < 75) ? MODE_CHUNKED : MODE_CLOSE;
            write_reg(CFG_BODY_MODE, mode);
            case (mode)
                MODE_NONE: begin
                    repeat ($urandom_range(4, 12))
                        push_raw(8'($urandom_range(255)), 1'($urandom_range(1)));
                end
                MODE_LENGTH: begin
                    decl = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 24);
                    write_reg(CFG_DECLARED_LENGTH, LEN_W'(decl));
                    write_reg(CFG_SIZE_LIMIT,
                              $urandom_range(1) ? LEN_W'(decl) : roomy_limit());
                    repeat ($urandom_range(2, 6)) begin
                        if (decl == 0)
                            push_raw(8'($urandom_range(255)), 1'($urandom_range(1)));
                        else
                            repeat (decl) push_framed(8'($urandom_range(255)));
                    end
                end
                MODE_CHUNKED: begin
                    if (cfg_limit < 200 || $urandom_range(1)) write_reg(CFG_SIZE_LIMIT, roomy_limit());
                    repeat ($urandom_range(1, 3)) queue_chunked_body($urandom_range(0, 3));
                end
                default: begin
                    if (cfg_limit < 200 || $urandom_range(1)) write_reg(CFG_SIZE_LIMIT, roomy_limit());
                    repeat ($urandom_range(2, 5)) begin
                        repeat ($urandom_range(0, 24)) push_raw(8'($urandom_range(255)), 1'b0);
                        push_raw(8'($urandom_range(255)), 1'b1);
                    end
                end
            endcase
            wait_drained();
        end

        // closing broken sequence; the error it raises holds for the rest of the run
        case ($urandom_range(5))
            0: begin
                write_reg(CFG_SIZE_LIMIT, LEN_W'($urandom_range(1000)));
                write_reg(CFG_DECLARED_LENGTH, '1);
                write_reg(CFG_BODY_MODE, MODE_LENGTH);
                push_raw(8'($urandom_range(255)), 1'b0);
            end
            1: begin
                write_reg(CFG_SIZE_LIMIT, '1);
                write_reg(CFG_BODY_MODE, MODE_CHUNKED);
                push_framed(8'h31);
                // characters outside the hex ranges, most of them just outside
                case ($urandom_range(8))
                    0: junk = 8'h2F;
                    1: junk = 8'h3A;
                    2: junk = 8'h40;
                    3: junk = 8'h47;
                    4: junk = 8'h60;
                    5: junk = 8'h67;
                    6: junk = 8'h20;
                    7: junk = CH_LF;
                    default: junk = 8'hB0;
                endcase
                push_raw(junk, 1'b0);
            end
            2: begin
                write_reg(CFG_SIZE_LIMIT, '1);
                write_reg(CFG_BODY_MODE, MODE_CHUNKED);
                queue_size_line(2, 0);
                push_framed(8'($urandom_range(255)));
                push_framed(8'($urandom_range(255)));
                junk = 8'($urandom_range(255));
                if ($urandom_range(1)) begin
                    push_raw((junk == CH_CR) ? CH_LF : junk, 1'b0);
                end else begin
                    push_raw(CH_CR, 1'b0);
                    push_raw((junk == CH_LF) ? CH_CR : junk, 1'b0);
                end
            end
            3: begin
                lim = $urandom_range(0, 40);
                write_reg(CFG_SIZE_LIMIT, LEN_W'(lim));
                write_reg(CFG_BODY_MODE, MODE_CHUNKED);
                queue_size_line(lim + 1 + $urandom_range(0, 20), 0);
            end
            4: begin
                lim = $urandom_range(0, 20);
                write_reg(CFG_SIZE_LIMIT, LEN_W'(lim));
                write_reg(CFG_BODY_MODE, MODE_CLOSE);
                repeat (lim + 1) push_raw(8'($urandom_range(255)), 1'b0);
            end
            default: begin
                write_reg(CFG_SIZE_LIMIT, '1);
                write_reg(CFG_BODY_MODE, MODE_CHUNKED);
                case ($urandom_range(2))
                    0: begin
                        // empty size line
                        push_raw(CH_CR, 1'b0);
                        push_raw(CH_LF, 1'b0);
                    end
                    1: begin
                        // CR without LF after the digits
                        push_raw(8'h35, 1'b0);
                        push_raw(CH_CR, 1'b0);
                        junk = 8'($urandom_range(255));
                        push_raw((junk == CH_LF) ? CH_CR : junk, 1'b0);
                    end
                    default: begin
                        // size does not fit in the length width
                        push_framed(8'h31);
                        repeat (10) push_framed(CH_ZERO);
                    end
                endcase
            end
        endcase
        repeat (8) push_raw(8'($urandom_range(255)), 1'($urandom_range(1)));
        wait_drained();
        repeat (8) @(posedge i_clk);

        if (fail_count == 0 && predicted_results.size() == 0) begin
            $display("http_body_chunked_deframer: match");
        end else begin
            $display("http_body_chunked_deframer: mismatch");
        end
        $finish;
    end

endmodule

`default_nettype wire

### sim.f
sv/chd_pkg.sv
sv/chd_cfg.sv
sv/chd_core.sv
sv/http_body_chunked_deframer.sv
tb/http_body_chunked_deframer_test.sv
